### hw/rtl/pbta_pkg.sv
// Package for the power-of-two bucket allocator: sizes, header and word types,
// status and opcode codes, controller states.
// No dependencies.
`default_nettype none

package pbta_pkg;

   localparam int HEAP_BYTES   = 1048576;
   localparam int NUM_BUCKETS  = 20;
   localparam int GRANULES     = HEAP_BYTES / 16;
   localparam int GRAN_W       = $clog2(GRANULES);      // granule index
   localparam int LINK_W       = GRAN_W + 1;            // granule + 1, 0 = none
   localparam int BUCKET_W     = $clog2(NUM_BUCKETS);
   localparam int BUMP_W       = $clog2(HEAP_BYTES) + 1;
   localparam int HDR_BYTES    = 4;
   localparam int PAGE_LOG2_MIN   = 4;
   localparam int PAGE_LOG2_MAX   = 16;
   localparam int PAGE_LOG2_RESET = 12;

   localparam logic OPCODE_ALLOC = 1'b0;
   localparam logic OPCODE_FREE  = 1'b1;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_NOMEM   = 2'd1;
   localparam logic [1:0] STATUS_IGNORED = 2'd2;

   typedef struct packed {
      logic        opcode;
      logic [20:0] request_bytes;
      logic [19:0] address;
   } req_word_type;

   typedef struct packed {
      logic [19:0] user_address;
      logic [1:0]  status;
   } rsp_word_type;

   typedef struct packed {
      logic                used;
      logic [BUCKET_W-1:0] bucket;
      logic [LINK_W-1:0]   link;
   } hdr_type;

   typedef struct packed {
      logic                too_large;
      logic [BUCKET_W-1:0] bucket;
   } class_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CLASS,
      ST_HEAD,
      ST_REFILL,
      ST_POP_RD,
      ST_POP_WR,
      ST_FREE_RD,
      ST_FREE_WR
   } fsm_state_type;

endpackage

`default_nettype wire

### hw/rtl/power_of_two_bucket_allocator.sv
// Power-of-two bucket allocator: free lists per size class over a 1 MiB heap.
// An allocation classes the size, reads the list head, refills an empty list by cutting
// up to page/16 blocks from the bump pointer, then pops the head with a header
// read-modify-write; a free reads the header and pushes the block. One word at a time.
// Reset: synchronous; a clearing pass then writes all 65536 headers, one per cycle,
// with busy high. The response strobe cannot be stalled.
// Depends on pbta_pkg, pbta_ram, pbta_class.
`default_nettype none

module power_of_two_bucket_allocator (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // command channel
   input  wire logic                   start,
   output logic                        busy,
   input  wire pbta_pkg::req_word_type req_data,
   // result channel, one-cycle strobe
   output logic                        rsp_valid,
   output pbta_pkg::rsp_word_type      rsp_data,
   // page size register
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [4:0]             csr_data
);

   localparam int GW = pbta_pkg::GRAN_W;
   localparam int LW = pbta_pkg::LINK_W;
   localparam int BW = pbta_pkg::BUCKET_W;
   localparam int PW = pbta_pkg::BUMP_W;

   // ---------------------------------------------------------------- state
   pbta_pkg::fsm_state_type state_ff, state_in;
   logic [LW-1:0]           clr_cnt_ff, clr_cnt_in;      // clearing-pass address
   pbta_pkg::req_word_type  req_ff, req_in;              // word being worked
   logic [BW-1:0]           bucket_ff, bucket_in;
   logic                    too_large_ff, too_large_in;
   logic [PW-1:0]           bump_ff, bump_in;            // first unused heap byte
   logic [LW-1:0]           cur_g_ff, cur_g_in;          // refill walk cursor
   logic [LW-1:0]           end_g_ff, end_g_in;
   logic [LW-1:0]           step_g_ff, step_g_in;
   logic                    large_ff, large_in;          // one-block refill
   logic [GW-1:0]           pop_g_ff, pop_g_in;          // granule in the RMW
   logic                    rsp_valid_ff, rsp_valid_in;
   pbta_pkg::rsp_word_type  rsp_data_ff, rsp_data_in;
   logic [4:0]              page_ff;

   // list heads: granule + 1, 0 = empty; small enough to live in flops
   logic [LW-1:0]           heads_ff [pbta_pkg::NUM_BUCKETS];
   logic                    heads_we;
   logic [BW-1:0]           heads_wa;
   logic [LW-1:0]           heads_wd;

   // header RAM port signals
   logic                    ram_we;
   logic [GW-1:0]           ram_wa;
   pbta_pkg::hdr_type       ram_wd;
   logic [GW-1:0]           ram_ra;
   pbta_pkg::hdr_type       ram_rd;

   pbta_pkg::class_type     cls;

   // ---------------------------------------------------------------- helpers
   logic [4:0]              page_eff;
   logic [LW-1:0]           head_cur;        // head of bucket_ff
   logic [LW-1:0]           head_freed;      // head of the freed block's bucket
   logic                    freed_bucket_ok;
   logic [23:0]             size_bytes;
   logic [23:0]             page_bytes;
   logic [23:0]             refill_bytes;
   logic [24:0]             bump_after;
   logic [23:0]             page_end;
   logic                    small_cls;
   logic                    refill_fits;
   logic [LW-1:0]           cur_next;
   logic                    refill_last;
   logic [LW-1:0]           pop_link;        // head minus one
   logic                    free_addr_ok;

   always_comb begin
      if (page_ff < 5'(pbta_pkg::PAGE_LOG2_MIN)) begin
         page_eff = 5'(pbta_pkg::PAGE_LOG2_MIN);
      end else if (page_ff > 5'(pbta_pkg::PAGE_LOG2_MAX)) begin
         page_eff = 5'(pbta_pkg::PAGE_LOG2_MAX);
      end else begin
         page_eff = page_ff;
      end
   end

   always_comb begin
      head_cur = '0;
      if ({1'b0, bucket_ff} < (BW+1)'(pbta_pkg::NUM_BUCKETS)) begin
         head_cur = heads_ff[bucket_ff];
      end
      freed_bucket_ok = ({1'b0, ram_rd.bucket} < (BW+1)'(pbta_pkg::NUM_BUCKETS));
      head_freed = '0;
      if (freed_bucket_ok) begin
         head_freed = heads_ff[ram_rd.bucket];
      end
   end

   // refill geometry: a class below a page cuts one page into a chain,
   // a larger class takes one block of its size plus a page
   always_comb begin
      size_bytes   = 24'd1 << (bucket_ff + BW'(3));
      page_bytes   = 24'd1 << page_eff;
      small_cls    = (({1'b0, bucket_ff} + 6'd3) < {1'b0, page_eff});
      refill_bytes = small_cls ? page_bytes : (size_bytes + page_bytes);
      bump_after   = {4'd0, bump_ff} + {1'b0, refill_bytes};
      refill_fits  = (bump_after <= 25'(pbta_pkg::HEAP_BYTES));
      page_end     = {3'd0, bump_ff} + page_bytes;
      cur_next     = cur_g_ff + step_g_ff;
      refill_last  = large_ff || (cur_next == end_g_ff);
      pop_link     = head_cur - LW'(1);
      free_addr_ok = (req_ff.address[3:0] == 4'(pbta_pkg::HDR_BYTES)) &&
                     ({1'b0, req_ff.address[19:4]} < LW'(pbta_pkg::GRANULES));
   end

   pbta_class u_class (
      .request_bytes (req_ff.request_bytes),
      .page_log2     (page_eff),
      .class_out     (cls)
   );

   pbta_ram #(
      .WIDTH ($bits(pbta_pkg::hdr_type)),
      .DEPTH (pbta_pkg::GRANULES)
   ) u_hdr_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pbta_pkg::ST_CLEAR: begin
            if (clr_cnt_ff == LW'(pbta_pkg::GRANULES - 1)) begin
               state_in = pbta_pkg::ST_IDLE;
            end
         end
         pbta_pkg::ST_IDLE: begin
            if (start) begin
               state_in = (req_data.opcode == pbta_pkg::OPCODE_FREE) ?
                          pbta_pkg::ST_FREE_RD : pbta_pkg::ST_CLASS;
            end
         end
         pbta_pkg::ST_CLASS: state_in = pbta_pkg::ST_HEAD;
         pbta_pkg::ST_HEAD: begin
            if (too_large_ff) begin
               state_in = pbta_pkg::ST_IDLE;
            end else if (head_cur != '0) begin
               state_in = pbta_pkg::ST_POP_RD;
            end else if (refill_fits) begin
               state_in = pbta_pkg::ST_REFILL;
            end else begin
               state_in = pbta_pkg::ST_IDLE;
            end
         end
         pbta_pkg::ST_REFILL: begin
            if (refill_last) begin
               state_in = pbta_pkg::ST_POP_RD;
            end
         end
         pbta_pkg::ST_POP_RD: begin
            if (head_cur == '0 || head_cur > LW'(pbta_pkg::GRANULES)) begin
               state_in = pbta_pkg::ST_IDLE;
            end else begin
               state_in = pbta_pkg::ST_POP_WR;
            end
         end
         pbta_pkg::ST_POP_WR: state_in = pbta_pkg::ST_IDLE;
         pbta_pkg::ST_FREE_RD: begin
            state_in = free_addr_ok ? pbta_pkg::ST_FREE_WR : pbta_pkg::ST_IDLE;
         end
         pbta_pkg::ST_FREE_WR: state_in = pbta_pkg::ST_IDLE;
         default: state_in = pbta_pkg::ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- outputs
   always_comb begin
      busy         = (state_ff != pbta_pkg::ST_IDLE);
      clr_cnt_in   = clr_cnt_ff;
      req_in       = req_ff;
      bucket_in    = bucket_ff;
      too_large_in = too_large_ff;
      bump_in      = bump_ff;
      cur_g_in     = cur_g_ff;
      end_g_in     = end_g_ff;
      step_g_in    = step_g_ff;
      large_in     = large_ff;
      pop_g_in     = pop_g_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      heads_we     = 1'b0;
      heads_wa     = bucket_ff;
      heads_wd     = '0;
      ram_we       = 1'b0;
      ram_wa       = pop_g_ff;
      ram_wd       = '0;
      ram_ra       = pop_g_ff;

      unique case (state_ff)
         pbta_pkg::ST_CLEAR: begin
            ram_we     = 1'b1;
            ram_wa     = clr_cnt_ff[GW-1:0];
            clr_cnt_in = clr_cnt_ff + LW'(1);
         end
         pbta_pkg::ST_IDLE: begin
            if (start) begin
               req_in = req_data;
            end
         end
         pbta_pkg::ST_CLASS: begin
            bucket_in    = cls.bucket;
            too_large_in = cls.too_large;
         end
         pbta_pkg::ST_HEAD: begin
            if (too_large_ff || (head_cur == '0 && !refill_fits)) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{user_address: '0, status: pbta_pkg::STATUS_NOMEM};
            end else if (head_cur == '0) begin
               // list head set now; the walk below writes the chain it names
               heads_we  = 1'b1;
               heads_wd  = bump_ff[PW-1:4] + LW'(1);
               bump_in   = bump_after[PW-1:0];
               cur_g_in  = bump_ff[PW-1:4];
               end_g_in  = page_end[PW-1:4];
               step_g_in = size_bytes[PW-1:4];
               large_in  = !small_cls;
            end
         end
         pbta_pkg::ST_REFILL: begin
            ram_we        = 1'b1;
            ram_wa        = cur_g_ff[GW-1:0];
            ram_wd.used   = 1'b0;
            ram_wd.bucket = bucket_ff;
            ram_wd.link   = refill_last ? '0 : (cur_next + LW'(1));
            cur_g_in      = cur_next;
         end
         pbta_pkg::ST_POP_RD: begin
            ram_ra   = pop_link[GW-1:0];
            pop_g_in = pop_link[GW-1:0];
            if (head_cur == '0 || head_cur > LW'(pbta_pkg::GRANULES)) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{user_address: '0, status: pbta_pkg::STATUS_NOMEM};
            end
         end
         pbta_pkg::ST_POP_WR: begin
            heads_we      = 1'b1;
            heads_wd      = ram_rd.link;
            ram_we        = 1'b1;
            ram_wd.used   = 1'b1;
            ram_wd.bucket = bucket_ff;
            ram_wd.link   = '0;
            rsp_valid_in  = 1'b1;
            rsp_data_in   = '{user_address: {pop_g_ff, 4'(pbta_pkg::HDR_BYTES)},
                              status: pbta_pkg::STATUS_OK};
         end
         pbta_pkg::ST_FREE_RD: begin
            ram_ra   = req_ff.address[19:4];
            pop_g_in = req_ff.address[19:4];
            if (!free_addr_ok) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{user_address: '0, status: pbta_pkg::STATUS_IGNORED};
            end
         end
         pbta_pkg::ST_FREE_WR: begin
            rsp_valid_in = 1'b1;
            if (ram_rd.used && freed_bucket_ok) begin
               // push onto the bucket list recorded in the header
               heads_we      = 1'b1;
               heads_wa      = ram_rd.bucket;
               heads_wd      = {1'b0, pop_g_ff} + LW'(1);
               ram_we        = 1'b1;
               ram_wd.used   = 1'b0;
               ram_wd.bucket = ram_rd.bucket;
               ram_wd.link   = head_freed;
               rsp_data_in   = '{user_address: '0, status: pbta_pkg::STATUS_OK};
            end else begin
               rsp_data_in   = '{user_address: '0, status: pbta_pkg::STATUS_IGNORED};
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pbta_pkg::ST_CLEAR;
         clr_cnt_ff   <= '0;
         bump_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         page_ff      <= 5'(pbta_pkg::PAGE_LOG2_RESET);
         for (int i = 0; i < pbta_pkg::NUM_BUCKETS; i++) begin
            heads_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         bump_ff      <= bump_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            page_ff <= csr_data;
         end
         if (heads_we) begin
            heads_ff[heads_wa] <= heads_wd;
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      bucket_ff    <= bucket_in;
      too_large_ff <= too_large_in;
      cur_g_ff     <= cur_g_in;
      end_g_ff     <= end_g_in;
      step_g_ff    <= step_g_in;
      large_ff     <= large_in;
      pop_g_ff     <= pop_g_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

`ifndef NO_ASSERTIONS
   // at most one result word per accepted command, never back to back
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe held for two cycles");

   // the cycle after accepting a command cannot already carry its result
   a_rsp_not_early: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> !rsp_valid_ff)
      else $error("result strobe right after accept");

   // carving never moves the bump pointer past the heap
   a_bump_bound: assert property (@(posedge clock) disable iff (reset)
      bump_ff <= PW'(pbta_pkg::HEAP_BYTES))
      else $error("bump pointer beyond heap");

   // every granted address sits just past a granule header
   a_addr_aligned: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.user_address != '0)
         |-> (rsp_data_ff.user_address[3:0] == 4'(pbta_pkg::HDR_BYTES)
              && rsp_data_ff.status == pbta_pkg::STATUS_OK))
      else $error("misaligned granted address");
`endif

endmodule

`default_nettype wire

### hw/rtl/pbta_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none

module pbta_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### hw/rtl/pbta_class.sv
// Size-class mapper: request byte count and page size to bucket number.
// Depends on pbta_pkg.
`default_nettype none

module pbta_class (
   input  wire logic [20:0]                   request_bytes,
   input  wire logic [4:0]                    page_log2,
   output pbta_pkg::class_type                class_out
);

   logic [21:0] need;
   logic [21:0] page_bytes;
   logic [21:0] excess;
   logic [21:0] excess_m1;
   logic        sub_page;
   logic [4:0]  lo;
   logic [4:0]  flog;
   logic [4:0]  clog;
   logic [4:0]  bucket;

   always_comb begin
      need       = {1'b0, request_bytes} + 22'(pbta_pkg::HDR_BYTES);
      page_bytes = 22'd1 << page_log2;
      sub_page   = (need <= page_bytes);
      // above a page the class covers page + 2^(b+3), so size the excess
      excess     = sub_page ? need : (need - page_bytes);
      lo         = sub_page ? 5'd1 : (page_log2 - 5'd3);
      excess_m1  = excess - 22'd1;
      flog       = '0;
      for (int i = 0; i < 22; i++) begin
         if (excess_m1[i]) begin
            flog = 5'(i);
         end
      end
      clog   = (excess <= 22'd1) ? 5'd0 : (flog + 5'd1);
      bucket = (clog <= (lo + 5'd3)) ? lo : (clog - 5'd3);
      class_out.bucket    = bucket[pbta_pkg::BUCKET_W-1:0];
      class_out.too_large = ({1'b0, bucket} >= 6'(pbta_pkg::NUM_BUCKETS));
   end

endmodule

`default_nettype wire
